// ===== design/r5rd_pkg.sv =====
`default_nettype none

package r5rd_pkg;

    // Fixed field widths
    localparam int DISK_IDX_W = 4;
    localparam int BLOCK_IDX_W = 10;
    localparam int WORD_W = 32;
    localparam int LBLOCK_W = 14;
    localparam int STATUS_W = 2;

    // Configuration register widths
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int NDISK_W = 5;
    localparam int STRIPE_W = 11;
    localparam int MASK_W = 16;
    localparam int BPD_W = 11;

    // Internal arithmetic widths
    localparam int DIV_W = 16;
    localparam int PG_W = 16;
    localparam int TOT_W = 27;

    // Opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIPE_WORDS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_MASK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_PER_DISK = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_DIRECT = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_REBUILT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNAVAIL = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

    typedef struct packed {
        logic                   opcode;
        logic [DISK_IDX_W-1:0]  disk_index;
        logic [BLOCK_IDX_W-1:0] block_index;
        logic [WORD_W-1:0]      load_word;
        logic [LBLOCK_W-1:0]    logical_block;
    } t_item;

    typedef struct packed {
        logic [WORD_W-1:0]   read_word;
        logic [STATUS_W-1:0] status;
    } t_result;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_GRP,
        ST_MUL_PG,
        ST_MUL_TOT,
        ST_CMP,
        ST_DIV_G,
        ST_DIV_GN,
        ST_DIV_RS,
        ST_MAP,
        ST_LOOKUP,
        ST_RD_WAIT,
        ST_SWEEP,
        ST_DRAIN
    } t_state;

endpackage

`default_nettype wire

// ===== design/r5rd_divider.sv =====
`default_nettype none

// Restoring radix-2 divider, one quotient bit per cycle.
module r5rd_divider import r5rd_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_dvs;

    logic [DIV_W:0] shifted;
    logic [DIV_W:0] diff;
    logic           fits;

    assign shifted = {r_rem, r_quo[DIV_W-1]};
    assign diff = shifted - {1'b0, r_dvs};
    assign fits = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt <= CNT_W'(DIV_W);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end else if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quotient = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

// ===== design/r5rd_store.sv =====
`default_nettype none

// Word store for all disks: one write port, one registered read port.
module r5rd_store import r5rd_pkg::*; #(
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WORD_W-1:0]        i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WORD_W-1:0]             o_rdata
);

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/raid5_block_read_rebuild.sv =====
`default_nettype none

// RAID5 read engine, left-symmetric rotating parity, single-disk rebuild.
//
// Command channel: an item transfers on a clock edge with start high and busy
// low. A load (opcode 0) writes one word into the disk store in that cycle
// and never raises busy; the next item can follow at once. A query (opcode 1)
// raises busy until its result is out, unless the geometry is bad.
// Result channel: o_strobe is high for exactly one cycle with o_result; the
// receiver cannot stall it. busy is already low in the strobe cycle, so the
// next item may transfer while the result is shown.
// Config port: i_cfg_we writes register i_cfg_index with i_cfg_data;
// write only while busy is low.
// Bad geometry answers in the cycle after the query transfers. Otherwise the
// query makes one pass through the shared 16-bit serial divider for its range
// check and three more to map the block; a parity rebuild then reads the disks
// from the store one after another, since the store has one read port.
// Reset: registers go to disk_count 2, stripe_words 1, mask 0, blocks 0.
// The store is not cleared; words must be loaded before they are read.

module raid5_block_read_rebuild import r5rd_pkg::*; #(
    parameter int MAX_DISKS = 16,
    parameter int MAX_BLOCKS = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_item                 i_item,
    output logic                       o_strobe,
    output t_result                    o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH = MAX_DISKS * MAX_BLOCKS;
    localparam int AW = $clog2(DEPTH);
    localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    // config registers
    logic [NDISK_W-1:0]  r_n;
    logic [STRIPE_W-1:0] r_s;
    logic [MASK_W-1:0]   r_mask;
    logic [BPD_W-1:0]    r_bpd;

    // control
    t_state  r_state, n_state;
    logic    r_strobe, n_strobe;
    t_result r_result, n_result;

    // query datapath
    logic [LBLOCK_W-1:0] r_c;
    logic [BPD_W-1:0]    r_groups;
    logic [PG_W-1:0]     r_pg;
    logic [TOT_W-1:0]    r_tot;
    logic [LBLOCK_W-1:0] r_g;
    logic [DIV_W-1:0]    r_r;
    logic [NDISK_W-1:0]  r_gmodn;
    logic [NDISK_W-1:0]  r_unit;
    logic [STRIPE_W-1:0] r_off;
    logic [NDISK_W-1:0]  r_tgt;
    logic [BW-1:0]       r_blk;
    logic [NDISK_W-1:0]  r_d;
    logic                r_prev_up;
    logic [WORD_W-1:0]   r_acc;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic              accept;
    logic              geo_ok;
    logic              load_ok;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [WORD_W-1:0] mem_rdata;
    logic              tgt_up;
    logic              other_missing;
    logic [NDISK_W:0]  map_sum;
    logic [NDISK_W-1:0] map_pn;
    logic [TOT_W-1:0]  map_blk;

    function automatic logic disk_up(input logic [MASK_W-1:0] mask,
                                     input logic [NDISK_W-1:0] d);
        return (d < NDISK_W'(MASK_W)) && mask[d[3:0]];
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [NDISK_W-1:0] d,
                                              input logic [BW-1:0] b);
        return AW'(d) * AW'(MAX_BLOCKS) + AW'(b);
    endfunction

    assign busy = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    assign geo_ok = (r_n >= NDISK_W'(2)) && (32'(r_n) <= MAX_DISKS)
                 && (r_s != '0) && (32'(r_bpd) <= MAX_BLOCKS);

    // loads go straight to the store; out-of-range ones are dropped
    assign load_ok = (32'(i_item.disk_index) < MAX_DISKS)
                  && (32'(i_item.block_index) < MAX_BLOCKS);
    assign mem_we = accept && (i_item.opcode == OP_LOAD) && load_ok;
    assign mem_waddr = AW'(i_item.disk_index) * AW'(MAX_BLOCKS) + AW'(i_item.block_index);

    assign tgt_up = disk_up(r_mask, r_tgt);

    // any missing disk in the array besides the target
    always_comb begin
        other_missing = 1'b0;
        for (int d = 0; d < (1 << NDISK_W); d++) begin
            if ((NDISK_W'(d) < r_n) && !disk_up(r_mask, NDISK_W'(d))
                && (NDISK_W'(d) != r_tgt)) begin
                other_missing = 1'b1;
            end
        end
    end

    // parity disk of the group, then the data disk after it (mod n)
    assign map_pn = r_n - NDISK_W'(1) - r_gmodn;
    assign map_sum = (NDISK_W + 1)'(map_pn) + (NDISK_W + 1)'(r_unit)
                   + (NDISK_W + 1)'(1);
    assign map_blk = TOT_W'(r_g) * TOT_W'(r_s) + TOT_W'(r_off);

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= NDISK_W'(2);
            r_s <= STRIPE_W'(1);
            r_mask <= '0;
            r_bpd <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DISK_COUNT:      r_n <= i_cfg_data[NDISK_W-1:0];
                CFG_STRIPE_WORDS:    r_s <= i_cfg_data[STRIPE_W-1:0];
                CFG_PRESENT_MASK:    r_mask <= i_cfg_data[MASK_W-1:0];
                CFG_BLOCKS_PER_DISK: r_bpd <= i_cfg_data[BPD_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    always_comb begin
        n_state = r_state;
        n_strobe = 1'b0;
        n_result = r_result;
        div_req = '0;
        mem_re = 1'b0;
        mem_raddr = addr_of(r_tgt, r_blk);
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_item.opcode == OP_QUERY)) begin
                    if (geo_ok) begin
                        div_req.start = 1'b1;
                        div_req.dividend = DIV_W'(r_bpd);
                        div_req.divisor = DIV_W'(r_s);
                        n_state = ST_DIV_GRP;
                    end else begin
                        n_strobe = 1'b1;
                        n_result = '{read_word: '0, status: STAT_RANGE};
                    end
                end
            end
            ST_DIV_GRP: begin
                if (div_rsp.done) begin
                    n_state = ST_MUL_PG;
                end
            end
            ST_MUL_PG: n_state = ST_MUL_TOT;
            ST_MUL_TOT: n_state = ST_CMP;
            ST_CMP: begin
                if (TOT_W'(r_c) < r_tot) begin
                    div_req.start = 1'b1;
                    div_req.dividend = DIV_W'(r_c);
                    div_req.divisor = DIV_W'(r_pg);
                    n_state = ST_DIV_G;
                end else begin
                    n_strobe = 1'b1;
                    n_result = '{read_word: '0, status: STAT_RANGE};
                    n_state = ST_IDLE;
                end
            end
            ST_DIV_G: begin
                if (div_rsp.done) begin
                    div_req.start = 1'b1;
                    div_req.dividend = div_rsp.quotient;
                    div_req.divisor = DIV_W'(r_n);
                    n_state = ST_DIV_GN;
                end
            end
            ST_DIV_GN: begin
                if (div_rsp.done) begin
                    div_req.start = 1'b1;
                    div_req.dividend = r_r;
                    div_req.divisor = DIV_W'(r_s);
                    n_state = ST_DIV_RS;
                end
            end
            ST_DIV_RS: begin
                if (div_rsp.done) begin
                    n_state = ST_MAP;
                end
            end
            ST_MAP: n_state = ST_LOOKUP;
            ST_LOOKUP: begin
                if (tgt_up) begin
                    mem_re = 1'b1;
                    n_state = ST_RD_WAIT;
                end else if (other_missing) begin
                    n_strobe = 1'b1;
                    n_result = '{read_word: '0, status: STAT_UNAVAIL};
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_SWEEP;
                end
            end
            ST_RD_WAIT: begin
                n_strobe = 1'b1;
                n_result = '{read_word: mem_rdata, status: STAT_DIRECT};
                n_state = ST_IDLE;
            end
            ST_SWEEP: begin
                // one store read per present disk; its data folds in on the next cycle
                mem_re = disk_up(r_mask, r_d);
                mem_raddr = addr_of(r_d, r_blk);
                if (r_d == r_n - NDISK_W'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_strobe = 1'b1;
                n_result = '{read_word: r_prev_up ? (r_acc ^ mem_rdata) : r_acc,
                             status: STAT_REBUILT};
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // query datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_c <= i_item.logical_block;
                end
            end
            ST_DIV_GRP: begin
                if (div_rsp.done) begin
                    r_groups <= div_rsp.quotient[BPD_W-1:0];
                end
            end
            ST_MUL_PG: r_pg <= PG_W'(r_n - NDISK_W'(1)) * PG_W'(r_s);
            ST_MUL_TOT: r_tot <= TOT_W'(r_pg) * TOT_W'(r_groups);
            ST_DIV_G: begin
                if (div_rsp.done) begin
                    r_g <= div_rsp.quotient[LBLOCK_W-1:0];
                    r_r <= div_rsp.remainder;
                end
            end
            ST_DIV_GN: begin
                if (div_rsp.done) begin
                    r_gmodn <= div_rsp.remainder[NDISK_W-1:0];
                end
            end
            ST_DIV_RS: begin
                if (div_rsp.done) begin
                    r_unit <= div_rsp.quotient[NDISK_W-1:0];
                    r_off <= div_rsp.remainder[STRIPE_W-1:0];
                end
            end
            ST_MAP: begin
                r_tgt <= (map_sum >= (NDISK_W + 1)'(r_n))
                       ? NDISK_W'(map_sum - (NDISK_W + 1)'(r_n))
                       : NDISK_W'(map_sum);
                r_blk <= BW'(map_blk);
            end
            ST_LOOKUP: begin
                r_d <= '0;
                r_prev_up <= 1'b0;
                r_acc <= '0;
            end
            ST_SWEEP: begin
                r_d <= r_d + NDISK_W'(1);
                r_prev_up <= disk_up(r_mask, r_d);
                if (r_prev_up) begin
                    r_acc <= r_acc ^ mem_rdata;
                end
            end
            default: ;
        endcase
    end

    r5rd_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    r5rd_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_item.load_word),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // a result follows a query transfer or a query in progress
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy || start))
        else $error("result strobe without a query in progress");

    // loads complete in the transfer cycle
    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.opcode == OP_LOAD)) |=> !busy)
        else $error("load raised busy");

    // a query either starts work or answers at once
    a_query_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.opcode == OP_QUERY)) |=> (busy || o_strobe))
        else $error("query dropped");

    // failed reads carry a zero word
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && ((o_result.status == STAT_UNAVAIL)
                      || (o_result.status == STAT_RANGE)))
        |-> (o_result.read_word == '0))
        else $error("nonzero word on failed read");

endmodule

`default_nettype wire
